// File: rtl/core/acfp_pkg.sv
// ----------------------------------------------------------------------------
// acfp_pkg: shared types and constants of the actuator command frame parser
// Frame layout tables, byte actions, actuator codes and the result structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acfp_pkg;

  localparam int unsigned FrameLen = 27;
  localparam int unsigned PosW     = 5;
  localparam int unsigned TgtW     = 4;
  localparam int unsigned ValW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [ByteW-1:0] StartByte = 8'hEA;
  localparam logic [ValW-1:0]  CamDefault = 16'd1;
  localparam logic [ByteW-1:0] CamFirst   = 8'd1;
  localparam logic [ByteW-1:0] CamLast    = 8'd3;
  localparam int unsigned      LidBit     = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgServoMin = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgServoMax = 1'b1;

  localparam logic [ValW-1:0] ServoMinReset = 16'd1000;
  localparam logic [ValW-1:0] ServoMaxReset = 16'd2000;

  // Actuator codes.
  localparam logic [TgtW-1:0] TgtLeft     = 4'd0;
  localparam logic [TgtW-1:0] TgtRight    = 4'd1;
  localparam logic [TgtW-1:0] TgtPan      = 4'd2;
  localparam logic [TgtW-1:0] TgtTilt     = 4'd3;
  localparam logic [TgtW-1:0] TgtCamera   = 4'd4;
  localparam logic [TgtW-1:0] TgtTurret   = 4'd5;
  localparam logic [TgtW-1:0] TgtShoulder = 4'd6;
  localparam logic [TgtW-1:0] TgtElbow    = 4'd7;
  localparam logic [TgtW-1:0] TgtForearm  = 4'd8;
  localparam logic [TgtW-1:0] TgtHand     = 4'd9;
  localparam logic [TgtW-1:0] TgtLid      = 4'd10;
  localparam logic [TgtW-1:0] TgtShovel   = 4'd11;

  typedef enum logic [2:0] {
    ACT_HUNT,
    ACT_LOW,
    ACT_WORD,
    ACT_SILENT,
    ACT_CAMERA,
    ACT_LID,
    ACT_DROP
  } action_e;

  typedef struct packed {
    logic [TgtW-1:0] target;
    logic [ValW-1:0] value;
    logic            read_error;
  } acfp_result_t;

  typedef struct packed {
    logic            emit;
    acfp_result_t    result;
    logic [PosW-1:0] pos_next;
    logic            hold_load;
  } acfp_decode_t;

  // What the byte at a given frame position does.
  function automatic action_e pos_action(logic [PosW-1:0] pos);
    action_e act;
    unique case (pos) inside
      5'd0: act = ACT_HUNT;
      5'd1, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22,
      5'd25: act = ACT_LOW;
      5'd2, 5'd4, 5'd6, 5'd8, 5'd11, 5'd13, 5'd15, 5'd17, 5'd23,
      5'd26: act = ACT_WORD;
      5'd19, 5'd21: act = ACT_SILENT;
      5'd9: act = ACT_CAMERA;
      5'd24: act = ACT_LID;
      default: act = ACT_DROP;
    endcase
    return act;
  endfunction

  // Actuator addressed by the byte that completes a field.
  function automatic logic [TgtW-1:0] pos_target(logic [PosW-1:0] pos);
    logic [TgtW-1:0] tgt;
    unique case (pos)
      5'd2:    tgt = TgtLeft;
      5'd4:    tgt = TgtRight;
      5'd6:    tgt = TgtPan;
      5'd8:    tgt = TgtTilt;
      5'd9:    tgt = TgtCamera;
      5'd11:   tgt = TgtTurret;
      5'd13:   tgt = TgtShoulder;
      5'd15:   tgt = TgtElbow;
      5'd17:   tgt = TgtForearm;
      5'd23:   tgt = TgtHand;
      5'd24:   tgt = TgtLid;
      5'd26:   tgt = TgtShovel;
      default: tgt = TgtLeft;
    endcase
    return tgt;
  endfunction

endpackage

// File: rtl/core/acfp_frame_decode.sv
// ----------------------------------------------------------------------------
// acfp_frame_decode: per-byte frame decoder
// Works out the command, the next frame position and the hold load for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acfp_frame_decode (
  input  logic [acfp_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       rx_error_i,
  input  logic [acfp_pkg::PosW-1:0]  pos_i,
  input  logic [acfp_pkg::ByteW-1:0] hold_i,
  input  logic [acfp_pkg::ValW-1:0]  servo_min_i,
  input  logic [acfp_pkg::ValW-1:0]  servo_max_i,
  output acfp_pkg::acfp_decode_t     dec_o
);
  import acfp_pkg::*;

  action_e         action;
  logic [PosW-1:0] pos_adv;
  logic [ValW-1:0] word;
  logic [ValW-1:0] word_val;

  assign action  = pos_action(pos_i);
  assign pos_adv = (pos_i == PosW'(FrameLen - 1)) ? '0 : pos_i + 1'b1;
  assign word    = {rx_byte_i, hold_i};

  // Only the hand word is limited to the servo range; the lower limit wins.
  always_comb begin
    word_val = word;
    if (pos_target(pos_i) == TgtHand) begin
      if (word < servo_min_i) begin
        word_val = servo_min_i;
      end else if (word > servo_max_i) begin
        word_val = servo_max_i;
      end
    end
  end

  always_comb begin
    dec_o           = '0;
    dec_o.pos_next  = pos_i;
    dec_o.result.target = pos_target(pos_i);
    if (rx_error_i) begin
      dec_o.emit              = 1'b1;
      dec_o.result            = '0;
      dec_o.result.read_error = 1'b1;
    end else begin
      unique case (action)
        ACT_HUNT: begin
          dec_o.pos_next = (rx_byte_i == StartByte) ? PosW'(1) : '0;
        end
        ACT_LOW: begin
          dec_o.hold_load = 1'b1;
          dec_o.pos_next  = pos_adv;
        end
        ACT_WORD: begin
          dec_o.emit         = 1'b1;
          dec_o.result.value = word_val;
          dec_o.pos_next     = pos_adv;
        end
        ACT_SILENT: begin
          dec_o.pos_next = pos_adv;
        end
        ACT_CAMERA: begin
          dec_o.emit         = 1'b1;
          dec_o.result.value = (rx_byte_i >= CamFirst && rx_byte_i <= CamLast) ?
                               {{(ValW - ByteW){1'b0}}, rx_byte_i} : CamDefault;
          dec_o.pos_next     = pos_adv;
        end
        ACT_LID: begin
          dec_o.emit         = 1'b1;
          dec_o.result.value = rx_byte_i[LidBit] ? servo_min_i : servo_max_i;
          dec_o.pos_next     = pos_adv;
        end
        default: begin
          dec_o.pos_next = '0;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/acfp_out_reg.sv
// ----------------------------------------------------------------------------
// acfp_out_reg: result register of the frame parser
// Holds one command until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acfp_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  acfp_pkg::acfp_result_t result_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output acfp_pkg::acfp_result_t result_o,
  output logic                   in_ready_o
);
  import acfp_pkg::*;

  logic         valid_q, valid_d;
  acfp_result_t data_q;

  // The register may be refilled in the cycle its content is taken.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

// File: rtl/core/actuator_command_frame_parser.sv
// ----------------------------------------------------------------------------
// actuator_command_frame_parser: each command appears in the cycle after its byte transfer.
// Throughput one byte per cycle; a held command stalls input only if not taken.
// Reset (asynchronous, active low) returns to hunting and restores servo limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The parser hunts for the start byte and then walks a fixed 27-byte frame.
// Each byte is decoded in one pass of combinational logic against the frame
// position and the held low byte; the command it gives, if any, is written
// into the result register. The frame position and low-byte hold update at
// the same edge, so the next byte can be taken in the following cycle.
// A byte flagged with a receive error yields an error command and leaves the
// frame position and the hold untouched, also while hunting.
module actuator_command_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [acfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [acfp_pkg::ValW-1:0]     cfg_data_i,
  // Received bytes.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  logic                          s_axis_tuser,  // [0] rx_error
  // Actuator commands.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // [3:0] target, [19:4] value, zero pad
  output logic                          m_axis_tuser   // [0] read_error
);
  import acfp_pkg::*;

  logic [ValW-1:0]  servo_min_q;
  logic [ValW-1:0]  servo_max_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] hold_q, hold_d;

  logic             in_fire;
  acfp_decode_t     dec;
  acfp_result_t     res_out;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Configuration registers; writes happen only while the parser is idle is a rule for the user, not enforced here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_min_q <= ServoMinReset;
      servo_max_q <= ServoMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgServoMin: servo_min_q <= cfg_data_i;
        CfgServoMax: servo_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acfp_frame_decode u_decode (
    .rx_byte_i   (s_axis_tdata),
    .rx_error_i  (s_axis_tuser),
    .pos_i       (pos_q),
    .hold_i      (hold_q),
    .servo_min_i (servo_min_q),
    .servo_max_i (servo_max_q),
    .dec_o       (dec)
  );

  // Frame state only moves on a byte transfer.
  always_comb begin
    pos_d  = pos_q;
    hold_d = hold_q;
    if (in_fire) begin
      pos_d = dec.pos_next;
      if (dec.hold_load) begin
        hold_d = s_axis_tdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hold_q <= '0;
    end else begin
      pos_q  <= pos_d;
      hold_q <= hold_d;
    end
  end

  acfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire && dec.emit),
    .result_i    (dec.result),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .result_o    (res_out),
    .in_ready_o  (s_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, res_out.value, res_out.target};
  assign m_axis_tuser = res_out.read_error;

`ifndef SYNTHESIS
  // An errored byte always produces an error command in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser |=> m_axis_tvalid && m_axis_tuser)
    else $error("errored byte did not give an error command");

  // An errored byte must not move the frame position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser |=> $stable(pos_q))
    else $error("frame position moved on an errored byte");

  // The frame position never leaves the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(FrameLen))
    else $error("frame position out of range");

  // An error command carries zero target and value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error command with non-zero payload");

  // While hunting, a byte other than the start byte keeps the parser hunting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !s_axis_tuser && pos_q == '0 && s_axis_tdata != StartByte
    |=> pos_q == '0)
    else $error("left hunting without a start byte");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for actuator_command_frame_parser
// Streams received bytes into the parser and checks every actuator command
// against a local frame parser. The run opens with a directed frame of
// extreme values. Random frames, line noise, receive errors and cut-short
// frames follow, under several servo limit settings and with random
// back-pressure on both streams.
// ----------------------------------------------------------------------------

module tb_top;
  import acfp_pkg::*;

  // One received byte with its receive-error flag, as queued for the driver.
  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } rx_item_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = CfgServoMin;
  logic [ValW-1:0]     cfg_data_i     = '0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata   = '0;  // [7:0] rx_byte
  logic                s_axis_tuser   = 1'b0;  // [0] rx_error
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [23:0]         m_axis_tdata;  // [3:0] target, [19:4] value, zero pad
  logic                m_axis_tuser;  // [0] read_error

  // Bytes waiting to be driven, and commands the parser still owes us.
  rx_item_t     rx_pending[$];
  acfp_result_t cmds_due[$];

  // Local copy of the parser state and of the servo limits.
  logic [PosW-1:0]  frame_pos_q  = '0;
  logic [ByteW-1:0] low_hold_q   = '0;
  logic [ValW-1:0]  servo_min_q  = ServoMinReset;
  logic [ValW-1:0]  servo_max_q  = ServoMaxReset;

  // Idling control: percentage chance per cycle of starting an idle burst.
  int unsigned idle_pct   = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  int unsigned fault_count = 0;
  int unsigned n_bytes     = 0;
  int unsigned n_cmds      = 0;
  int unsigned n_err_cmds  = 0;
  int unsigned n_settings  = 0;

  rx_item_t     rx_next;
  acfp_result_t got;
  acfp_result_t want;

  actuator_command_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Frame parser used for prediction. It is called once for every byte that
  // the parser accepts, walks its own copy of the frame position and the
  // held low byte, and queues the command that the byte should produce.
  // --------------------------------------------------------------------------
  task automatic parse_rx_byte(input logic [7:0] b, input logic err);
    acfp_result_t    cmd;
    action_e         act;
    logic [ValW-1:0] word;
    logic [PosW-1:0] nxt;
    cmd = '0;
    // A byte with a receive error is reported and otherwise ignored, so the
    // frame position and the held low byte stay where they were.
    if (err) begin
      cmd.read_error = 1'b1;
      cmds_due.push_back(cmd);
      return;
    end
    word = {b, low_hold_q};
    nxt  = (frame_pos_q == FrameLen - 1) ? '0 : frame_pos_q + 1'b1;
    case (frame_pos_q)
      5'd0: act = ACT_HUNT;
      5'd1, 5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22,
      5'd25: act = ACT_LOW;
      5'd2: begin
        act = ACT_WORD; cmd.target = TgtLeft;
      end
      5'd4: begin
        act = ACT_WORD; cmd.target = TgtRight;
      end
      5'd6: begin
        act = ACT_WORD; cmd.target = TgtPan;
      end
      5'd8: begin
        act = ACT_WORD; cmd.target = TgtTilt;
      end
      5'd9: begin
        act = ACT_CAMERA; cmd.target = TgtCamera;
      end
      5'd11: begin
        act = ACT_WORD; cmd.target = TgtTurret;
      end
      5'd13: begin
        act = ACT_WORD; cmd.target = TgtShoulder;
      end
      5'd15: begin
        act = ACT_WORD; cmd.target = TgtElbow;
      end
      5'd17: begin
        act = ACT_WORD; cmd.target = TgtForearm;
      end
      5'd19, 5'd21: act = ACT_SILENT;
      5'd23: begin
        act = ACT_WORD; cmd.target = TgtHand;
      end
      5'd24: begin
        act = ACT_LID; cmd.target = TgtLid;
      end
      5'd26: begin
        act = ACT_WORD; cmd.target = TgtShovel;
      end
      default: act = ACT_DROP;
    endcase
    case (act)
      ACT_HUNT: nxt = (b == StartByte) ? 5'd1 : 5'd0;
      ACT_LOW:  low_hold_q = b;
      ACT_WORD: begin
        cmd.value = word;
        // The hand is clamped; the lower limit wins when the limits cross.
        if (cmd.target == TgtHand) begin
          if (word < servo_min_q) begin
            cmd.value = servo_min_q;
          end else if (word > servo_max_q) begin
            cmd.value = servo_max_q;
          end
        end
        cmds_due.push_back(cmd);
      end
      ACT_CAMERA: begin
        cmd.value = (b >= CamFirst && b <= CamLast) ? {8'h00, b} : CamDefault;
        cmds_due.push_back(cmd);
      end
      ACT_LID: begin
        // Bit 6 set opens the box lid, clear closes it.
        cmd.value = b[LidBit] ? servo_min_q : servo_max_q;
        cmds_due.push_back(cmd);
      end
      ACT_DROP: nxt = '0;
      default: ;  // wrist words are consumed without a command
    endcase
    frame_pos_q = nxt;
  endtask

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t: %s: expected target %0d value %0d err %0b, got target %0d value %0d err %0b",
               $time, what, want.target, want.value, want.read_error,
               got.target, got.value, got.read_error);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver. Predicts on each byte transfer and then offers the next queued
  // byte, with random idle bursts when idling is enabled.
  // Every signal receives a single nonblocking update per clock edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata, s_axis_tuser);
        n_bytes++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_pct != 0 && rx_pending.size() != 0 &&
                     $urandom_range(99, 0) < idle_pct) begin
          gap_left = $urandom_range(17, 0);
          s_axis_tvalid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          rx_next = rx_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= rx_next.data;
          s_axis_tuser  <= rx_next.err;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each command transfer is checked field by field against the
  // oldest outstanding expectation; tready stalls in random bursts as well.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.target     = m_axis_tdata[3:0];
        got.value      = m_axis_tdata[19:4];
        got.read_error = m_axis_tuser;
        if (cmds_due.size() == 0) begin
          want = '0;
          note_fault("command with none outstanding");
        end else begin
          want = cmds_due.pop_front();
          n_cmds++;
          if (want.read_error) begin
            n_err_cmds++;
          end
          if (got.target !== want.target || got.value !== want.value ||
              got.read_error !== want.read_error) begin
            note_fault("command mismatch");
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        stall_left = $urandom_range(17, 0);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic err);
    rx_item_t item;
    item.data = b;
    item.err  = err;
    rx_pending.push_back(item);
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0], 1'b0);
    send_byte(w[15:8], 1'b0);
  endtask

  // Line noise while hunting: never a clean start byte, sometimes errored.
  task automatic send_noise(input int unsigned count);
    logic [7:0] b;
    logic       err;
    repeat (count) begin
      b   = 8'($urandom_range(255, 0));
      err = ($urandom_range(4, 0) == 0);
      if (!err && b == StartByte) begin
        b = ~b;
      end
      send_byte(b, err);
    end
  endtask

  // One frame with random content. Receive errors are slipped in between
  // bytes; a cut-short frame leaves the parser misaligned against the next.
  task automatic send_random_frame(input int unsigned err_pct, input bit cut_short);
    logic [15:0] hand;
    logic [7:0]  b;
    int unsigned last;
    last = cut_short ? $urandom_range(FrameLen - 2, 1) : FrameLen - 1;
    send_byte(StartByte, 1'b0);
    for (int unsigned k = 1; k <= last; k++) begin
      if ($urandom_range(99, 0) < err_pct) begin
        send_byte(8'($urandom_range(255, 0)), 1'b1);
      end
      b = 8'($urandom_range(255, 0));
      if (k == 9) begin
        case ($urandom_range(3, 0))
          0: b = 8'($urandom_range(3, 1));
          1: b = 8'h00;
          2: b = 8'($urandom_range(255, 4));
          default: ;
        endcase
      end else if (k == 22) begin
        // Bias the hand towards both clamp limits and their neighbourhood.
        case ($urandom_range(5, 0))
          0: hand = 16'($urandom_range(servo_min_q, 0));
          1: hand = 16'($urandom_range(16'hFFFF, servo_max_q));
          2: hand = servo_min_q;
          3: hand = servo_max_q;
          4: hand = 16'($urandom_range(servo_max_q, servo_min_q));
          default: hand = 16'($urandom_range(16'hFFFF, 0));
        endcase
        b = hand[7:0];
      end else if (k == 23) begin
        b = hand[15:8];
      end
      send_byte(b, 1'b0);
    end
  endtask

  // Waits until every byte is taken and every command has come back, then
  // lets the latency of a silent last byte pass as well.
  task automatic wait_drained();
    while (rx_pending.size() != 0 || s_axis_tvalid || cmds_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_servo_limits(input logic [15:0] lo, input logic [15:0] hi);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgServoMin;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= CfgServoMax;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    servo_min_q = lo;
    servo_max_q = hi;
    n_settings++;
  endtask

  task automatic run_frames(input int unsigned frames, input int unsigned pct);
    idle_pct = pct;
    repeat (frames) begin
      send_noise($urandom_range(3, 0));
      send_random_frame(6, $urandom_range(9, 0) == 0);
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, a directed frame, then random phases under several
  // pairs of servo limits; written pairs are set while the parser is idle.
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] lim_a;
    logic [15:0] lim_b;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frame under the reset limits. An errored start byte must not
    // open a frame; the following clean one does.
    idle_pct = 25;
    send_byte(StartByte, 1'b1);
    send_byte(StartByte, 1'b0);
    send_word(16'h0000);               // left
    send_word(16'hFFFF);               // right
    send_word(16'h8001);               // pan
    send_word(16'h7FFE);               // tilt
    send_byte(8'h00, 1'b0);            // camera out of range, falls back to 1
    send_byte(8'h5A, 1'b1);            // errored byte mid-frame
    send_word(16'h1234);               // turret
    send_word(16'hA55A);               // shoulder
    send_word(16'h5AA5);               // elbow
    send_word(16'h00FF);               // forearm
    send_word(16'hFF00);               // wrist tilt
    send_word(16'h0101);               // wrist spin
    send_word(16'h0000);               // hand below the lower limit
    send_byte(8'h40, 1'b0);            // lid open
    send_word(16'hFFFF);               // shovel
    wait_drained();
    run_frames(3, 25);

    set_servo_limits(16'h0000, 16'hFFFF);
    run_frames(3, 10);

    // Crossed limits: the lower limit takes priority in the hand clamp.
    set_servo_limits(16'hFFFF, 16'h0000);
    run_frames(3, 40);

    lim_a = 16'($urandom_range(16'hFFFF, 0));
    set_servo_limits(lim_a, lim_a);
    run_frames(3, 0);

    lim_a = 16'($urandom_range(16'h7FFF, 0));
    lim_b = 16'($urandom_range(16'hFFFF, lim_a));
    set_servo_limits(lim_a, lim_b);
    run_frames(3, 25);

    // Closing stretch at full rate with no idling on either side.
    set_servo_limits(ServoMinReset, ServoMaxReset);
    run_frames(3, 0);

    $display("Covered %0d bytes and %0d commands, %0d of them receive-error reports,",
             n_bytes, n_cmds, n_err_cmds);
    $display("under reset limits and %0d written limit pairs, crossed and extreme ones included.",
             n_settings);
    if (fault_count == 0 && cmds_due.size() == 0) begin
      $display("actuator_command_frame_parser verification clean");
    end else begin
      $display("actuator_command_frame_parser verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, stalls and idling included.
  initial begin
    #1_000_000;
    $display("actuator_command_frame_parser verification failed");
    $finish;
  end

endmodule
